// ===== src/assert_macros.svh =====
// Assertion macros used by the blob tracker back end, cbcs_back.
// CBCS_ASSERT needs a clk and an active-low rst_n in scope; CBCS_ASSERT_ALWAYS only a clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CBCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CBCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cbcs_pkg.sv =====
// Shared types and constants of the color blob centroid tracker.
// No dependencies; used by every module of the block.
package cbcs_pkg;

    localparam int COORD_BITS = 10;
    localparam int COUNT_W    = 20;
    localparam int SUM_W      = 30;
    localparam int POS_W      = 11;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};

    // register indexes
    localparam logic [2:0] REG_HUE_MAX    = 3'd0;
    localparam logic [2:0] REG_SAT_MIN    = 3'd1;
    localparam logic [2:0] REG_VAL_MIN    = 3'd2;
    localparam logic [2:0] REG_AREA_MIN   = 3'd3;
    localparam logic [2:0] REG_TURN_LEFT  = 3'd4;
    localparam logic [2:0] REG_TURN_RIGHT = 3'd5;
    localparam logic [2:0] REG_STOP_LOW   = 3'd6;
    localparam logic [2:0] REG_STOP_HIGH  = 3'd7;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_STEER
    } back_state_t;

    typedef struct packed {
        logic [7:0]  hue_max;
        logic [7:0]  sat_min;
        logic [7:0]  val_min;
        logic [19:0] area_min;
        logic [9:0]  turn_left_below;
        logic [9:0]  turn_right_above;
        logic [9:0]  stop_band_low;
        logic [9:0]  stop_band_high;
    } cfg_t;

    // totals of one finished frame
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/cbcs_front.sv =====
// Front end: classifies pixels and accumulates count and coordinate sums.
// Depends on cbcs_pkg; pushes one frame record per frame into the queue.
module cbcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbcs_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic [7:0]                    hue,
    input  logic [7:0]                    saturation,
    input  logic [7:0]                    brightness,
    input  logic [9:0]                    pos_x,
    input  logic [9:0]                    pos_y,
    input  logic                          end_of_frame,
    output logic                          push,
    output cbcs_pkg::frame_rec_t          rec
);

    logic [cbcs_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [cbcs_pkg::SUM_W-1:0]   sumx_reg, sumx_next;
    logic [cbcs_pkg::SUM_W-1:0]   sumy_reg, sumy_next;
    logic                         marked;
    logic [cbcs_pkg::SUM_W:0]     addx, addy;

    always_comb
    begin
        marked = (hue <= cfg.hue_max) && (saturation >= cfg.sat_min) &&
                 (brightness >= cfg.val_min) && (count_reg != cbcs_pkg::COUNT_MAX);
        addx = {1'b0, sumx_reg} +
               (cbcs_pkg::SUM_W+1)'(pos_x[cbcs_pkg::COORD_BITS-1:0]);
        addy = {1'b0, sumy_reg} +
               (cbcs_pkg::SUM_W+1)'(pos_y[cbcs_pkg::COORD_BITS-1:0]);
        count_next = count_reg;
        sumx_next  = sumx_reg;
        sumy_next  = sumy_reg;
        if (marked)
        begin
            count_next = count_reg + 1'b1;
            // saturate the sums
            sumx_next = addx[cbcs_pkg::SUM_W] ? cbcs_pkg::SUM_MAX
                                              : addx[cbcs_pkg::SUM_W-1:0];
            sumy_next = addy[cbcs_pkg::SUM_W] ? cbcs_pkg::SUM_MAX
                                              : addy[cbcs_pkg::SUM_W-1:0];
        end
        push      = accept && end_of_frame;
        rec.count = count_next;
        rec.sum_x = sumx_next;
        rec.sum_y = sumy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
        end
        else if (accept)
        begin
            if (end_of_frame)
            begin
                count_reg <= '0;
                sumx_reg  <= '0;
                sumy_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sumx_reg  <= sumx_next;
                sumy_reg  <= sumy_next;
            end
        end
    end

endmodule

// ===== src/cbcs_queue.sv =====
// Two-entry queue of frame records between front and back end.
// Depends on cbcs_pkg.
module cbcs_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cbcs_pkg::frame_rec_t    push_rec,
    input  logic                    pop,
    output cbcs_pkg::frame_rec_t    head,
    output cbcs_pkg::queue_status_t status
);

    cbcs_pkg::frame_rec_t entry_reg [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           fill_reg;

    always_comb
    begin
        head         = entry_reg[rd_ptr_reg];
        status.full  = (fill_reg == 2'd2);
        status.empty = (fill_reg == 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== src/cbcs_back.sv =====
// Back end: bit-serial centroid division, steering decision, output register.
// Depends on cbcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbcs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbcs_pkg::cfg_t          cfg,
    input  cbcs_pkg::frame_rec_t    head,
    input  cbcs_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              command,
    output logic                    found,
    output logic [10:0]             centroid_x,
    output logic [10:0]             centroid_y
);

    localparam int CW = cbcs_pkg::COUNT_W;
    localparam int SW = cbcs_pkg::SUM_W;
    localparam int PW = cbcs_pkg::POS_W;

    cbcs_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]                    divisor_reg;
    logic [SW-1:0]                    qx_reg, qy_reg;
    logic [CW-1:0]                    rx_reg, ry_reg;
    logic [cbcs_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             hit_reg;
    logic signed [PW-1:0]             last_x_reg, last_y_reg, cmdx_reg;
    logic                             out_valid_reg;
    logic [1:0]                       cmd_out_reg;
    logic                             found_out_reg;
    logic [PW-1:0]                    cx_out_reg, cy_out_reg;

    logic [SW-1:0]        qx_step, qy_step;
    logic [CW-1:0]        rx_step, ry_step;
    logic                 fire;
    logic signed [PW-1:0] lx_new, ly_new;
    cbcs_pkg::cmd_t       cmd_new;

    // one restoring division step: shift in the next dividend bit
    function automatic logic [SW+CW-1:0] div_step(input logic [SW-1:0] q,
                                                  input logic [CW-1:0] r,
                                                  input logic [CW-1:0] d);
        logic [CW:0]   shifted;
        logic          take;
        logic [CW-1:0] r_out;
        shifted = {r, q[SW-1]};
        take    = (shifted >= {1'b0, d});
        r_out   = take ? CW'(shifted - {1'b0, d}) : shifted[CW-1:0];
        return {q[SW-2:0], take, r_out};
    endfunction

    function automatic logic signed [PW-1:0] clamp_pos(input logic [SW-1:0] q);
        logic [cbcs_pkg::COORD_BITS-1:0] c;
        c = (q > SW'(cbcs_pkg::COORD_MASK)) ? cbcs_pkg::COORD_MASK
                                            : q[cbcs_pkg::COORD_BITS-1:0];
        return PW'(c);
    endfunction

    always_comb
    begin
        {qx_step, rx_step} = div_step(qx_reg, rx_reg, divisor_reg);
        {qy_step, ry_step} = div_step(qy_reg, ry_reg, divisor_reg);

        lx_new = hit_reg ? clamp_pos(qx_reg) : last_x_reg;
        ly_new = hit_reg ? clamp_pos(qy_reg) : last_y_reg;

        cmd_new = cbcs_pkg::CMD_NONE;
        if ((cmdx_reg != lx_new) && (lx_new > 0))
        begin
            priority if (lx_new < $signed({1'b0, cfg.turn_left_below}))
                cmd_new = cbcs_pkg::CMD_LEFT;
            else if (lx_new > $signed({1'b0, cfg.turn_right_above}))
                cmd_new = cbcs_pkg::CMD_RIGHT;
            else if ((cmdx_reg < $signed({1'b0, cfg.stop_band_low})) ||
                     (cmdx_reg > $signed({1'b0, cfg.stop_band_high})))
                cmd_new = cbcs_pkg::CMD_STOP;
            else
                cmd_new = cbcs_pkg::CMD_NONE;
        end

        fire       = 1'b0;
        pop        = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            cbcs_pkg::BK_IDLE:
            begin
                if (!status.empty)
                begin
                    pop        = 1'b1;
                    state_next = (head.count > cfg.area_min) ? cbcs_pkg::BK_DIV
                                                             : cbcs_pkg::BK_STEER;
                end
            end
            cbcs_pkg::BK_DIV:
            begin
                if (cnt_reg == cbcs_pkg::DIV_CNT_W'(SW - 1))
                begin
                    state_next = cbcs_pkg::BK_STEER;
                end
            end
            cbcs_pkg::BK_STEER:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    fire       = 1'b1;
                    state_next = cbcs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cbcs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbcs_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            last_x_reg    <= '1;
            last_y_reg    <= '1;
            cmdx_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cnt_reg <= '0;
                hit_reg <= (head.count > cfg.area_min);
            end
            else if (state_reg == cbcs_pkg::BK_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (fire)
            begin
                last_x_reg    <= lx_new;
                last_y_reg    <= ly_new;
                out_valid_reg <= 1'b1;
                if ((cmdx_reg != lx_new) && (lx_new > 0))
                begin
                    cmdx_reg <= lx_new;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            divisor_reg <= head.count;
            qx_reg      <= head.sum_x;
            qy_reg      <= head.sum_y;
            rx_reg      <= '0;
            ry_reg      <= '0;
        end
        else if (state_reg == cbcs_pkg::BK_DIV)
        begin
            qx_reg <= qx_step;
            qy_reg <= qy_step;
            rx_reg <= rx_step;
            ry_reg <= ry_step;
        end
        if (fire)
        begin
            cmd_out_reg   <= cmd_new;
            found_out_reg <= hit_reg;
            cx_out_reg    <= lx_new;
            cy_out_reg    <= ly_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign command    = cmd_out_reg;
    assign found      = found_out_reg;
    assign centroid_x = cx_out_reg;
    assign centroid_y = cy_out_reg;

    `CBCS_ASSERT(a_div_nonzero, (state_reg == cbcs_pkg::BK_DIV) |-> (divisor_reg != '0),
                 "division started with a zero count")
    `CBCS_ASSERT(a_div_only_on_hit, (state_reg == cbcs_pkg::BK_DIV) |-> hit_reg,
                 "division running for a frame without a blob")
    `CBCS_ASSERT(a_no_overwrite, (out_valid_reg && !out_ready) |-> !fire,
                 "pending result overwritten")
    `CBCS_ASSERT(a_found_has_pos, (out_valid_reg && found_out_reg) |-> !cx_out_reg[PW-1],
                 "found result carries a negative centroid")
    `CBCS_ASSERT_ALWAYS(a_pop_in_idle, pop |-> (state_reg == cbcs_pkg::BK_IDLE),
                        "queue popped outside idle")

endmodule

// ===== src/color_blob_centroid_steer.sv =====
// Top level of the color blob centroid tracker: register file and wiring.
// Depends on cbcs_pkg, cbcs_front, cbcs_queue and cbcs_back.
//
//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------
//  s_*       | in        | one HSV pixel with coordinates, tlast ends frame
//  m_*       | out       | one steering result per frame
//  p*        | in/out    | APB register port, eight 32-bit registers
//
// A pixel beat is taken every cycle; the frame totals go to a two-entry queue.
// Each frame result passes from idle to steer, through a 30-step bit-serial divider
// for x and y in parallel when a blob is found, then waits in the output register.
// s_tready drops only while the queue holds two unfinished frames.
// Reset restores register defaults and clears all sums; no clearing pass.
module color_blob_centroid_steer (
    input  logic        clk,
    input  logic        rst_n,
    // [7:0] hue, [15:8] saturation, [23:16] brightness,
    // [33:24] pos_x, [43:34] pos_y, [47:44] zero
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tlast,
    // [1:0] command, [2] found, [13:3] centroid_x, [24:14] centroid_y,
    // [31:25] zero
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cbcs_pkg::cfg_t          cfg_reg;
    cbcs_pkg::frame_rec_t    push_rec, head;
    cbcs_pkg::queue_status_t status;
    logic                    accept, push, pop;
    logic [1:0]              command;
    logic                    found;
    logic [10:0]             centroid_x, centroid_y;
    logic [2:0]              reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_max          <= 8'd9;
            cfg_reg.sat_min          <= 8'd160;
            cfg_reg.val_min          <= 8'd40;
            cfg_reg.area_min         <= 20'd400;
            cfg_reg.turn_left_below  <= 10'd40;
            cfg_reg.turn_right_above <= 10'd120;
            cfg_reg.stop_band_low    <= 10'd60;
            cfg_reg.stop_band_high   <= 10'd100;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                cbcs_pkg::REG_HUE_MAX:    cfg_reg.hue_max          <= pwdata[7:0];
                cbcs_pkg::REG_SAT_MIN:    cfg_reg.sat_min          <= pwdata[7:0];
                cbcs_pkg::REG_VAL_MIN:    cfg_reg.val_min          <= pwdata[7:0];
                cbcs_pkg::REG_AREA_MIN:   cfg_reg.area_min         <= pwdata[19:0];
                cbcs_pkg::REG_TURN_LEFT:  cfg_reg.turn_left_below  <= pwdata[9:0];
                cbcs_pkg::REG_TURN_RIGHT: cfg_reg.turn_right_above <= pwdata[9:0];
                cbcs_pkg::REG_STOP_LOW:   cfg_reg.stop_band_low    <= pwdata[9:0];
                cbcs_pkg::REG_STOP_HIGH:  cfg_reg.stop_band_high   <= pwdata[9:0];
                default:                  cfg_reg.hue_max          <= cfg_reg.hue_max;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            cbcs_pkg::REG_HUE_MAX:    prdata = 32'(cfg_reg.hue_max);
            cbcs_pkg::REG_SAT_MIN:    prdata = 32'(cfg_reg.sat_min);
            cbcs_pkg::REG_VAL_MIN:    prdata = 32'(cfg_reg.val_min);
            cbcs_pkg::REG_AREA_MIN:   prdata = 32'(cfg_reg.area_min);
            cbcs_pkg::REG_TURN_LEFT:  prdata = 32'(cfg_reg.turn_left_below);
            cbcs_pkg::REG_TURN_RIGHT: prdata = 32'(cfg_reg.turn_right_above);
            cbcs_pkg::REG_STOP_LOW:   prdata = 32'(cfg_reg.stop_band_low);
            cbcs_pkg::REG_STOP_HIGH:  prdata = 32'(cfg_reg.stop_band_high);
            default:                  prdata = '0;
        endcase
    end

    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    cbcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .hue          (s_tdata[7:0]),
        .saturation   (s_tdata[15:8]),
        .brightness   (s_tdata[23:16]),
        .pos_x        (s_tdata[33:24]),
        .pos_y        (s_tdata[43:34]),
        .end_of_frame (s_tlast),
        .push         (push),
        .rec          (push_rec)
    );

    cbcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    cbcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .status     (status),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .command    (command),
        .found      (found),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y)
    );

    assign m_tdata = {7'd0, centroid_y, centroid_x, found, command};

endmodule

// ===== verif/blob_steer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the blob centroid tracker: it mirrors the APB registers and predicts one
// steering result per frame from the pixel beats, then compares the result beats.
// Depends on cbcs_pkg for the register indexes, command codes, config layout, widths and limits.
module blob_steer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tlast,
    input  logic [31:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          frames_pending,
    output int          frames_checked,
    output int          blobs_found
);

    localparam cbcs_pkg::cfg_t CFG_AT_RESET = '{hue_max: 8'd9, sat_min: 8'd160,
                                                val_min: 8'd40, area_min: 20'd400,
                                                turn_left_below: 10'd40,
                                                turn_right_above: 10'd120,
                                                stop_band_low: 10'd60,
                                                stop_band_high: 10'd100};

    typedef struct {
        cbcs_pkg::cmd_t     cmd;
        logic               found;
        logic signed [10:0] cx;
        logic signed [10:0] cy;
    } steer_t;

    cbcs_pkg::cfg_t                       cfg;
    logic [cbcs_pkg::COUNT_W-1:0]         blob_count;
    logic [cbcs_pkg::SUM_W-1:0]           blob_sum_x;
    logic [cbcs_pkg::SUM_W-1:0]           blob_sum_y;
    logic signed [10:0]                   last_cx;
    logic signed [10:0]                   last_cy;
    logic signed [10:0]                   steered_x;
    steer_t                               steer_queue[$];
    int                                   fail_total;
    int                                   checked_total;
    int                                   found_total;

    initial
    begin
        fail_total    = 0;
        checked_total = 0;
        found_total   = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_total++;
        $display("[%0t] steering result mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  bri;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [30:0] acc;
        logic [29:0] quot;
        int          cur_x;
        int          prev_x;
        int          left_lim;
        int          right_lim;
        int          band_lo;
        int          band_hi;
        steer_t      want;
        if (!rst_n)
        begin
            cfg        = CFG_AT_RESET;
            blob_count = '0;
            blob_sum_x = '0;
            blob_sum_y = '0;
            last_cx    = -11'sd1;
            last_cy    = -11'sd1;
            steered_x  = -11'sd1;
            steer_queue.delete();
        end
        else
        begin
            // a result never leaves in the cycle its frame ends, so compare first
            if (m_tvalid && m_tready)
            begin
                if (steer_queue.size() == 0)
                    report_mismatch("unexpected result beat", int'(m_tdata), 0);
                else
                begin
                    want = steer_queue.pop_front();
                    if (m_tdata[1:0] !== want.cmd)
                        report_mismatch("command", int'(m_tdata[1:0]), int'(want.cmd));
                    if (m_tdata[2] !== want.found)
                        report_mismatch("found", int'(m_tdata[2]), int'(want.found));
                    if ($signed(m_tdata[13:3]) !== want.cx)
                        report_mismatch("centroid_x", int'($signed(m_tdata[13:3])),
                                        int'(want.cx));
                    if ($signed(m_tdata[24:14]) !== want.cy)
                        report_mismatch("centroid_y", int'($signed(m_tdata[24:14])),
                                        int'(want.cy));
                    checked_total++;
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    cbcs_pkg::REG_HUE_MAX:    cfg.hue_max          = pwdata[7:0];
                    cbcs_pkg::REG_SAT_MIN:    cfg.sat_min          = pwdata[7:0];
                    cbcs_pkg::REG_VAL_MIN:    cfg.val_min          = pwdata[7:0];
                    cbcs_pkg::REG_AREA_MIN:   cfg.area_min         = pwdata[19:0];
                    cbcs_pkg::REG_TURN_LEFT:  cfg.turn_left_below  = pwdata[9:0];
                    cbcs_pkg::REG_TURN_RIGHT: cfg.turn_right_above = pwdata[9:0];
                    cbcs_pkg::REG_STOP_LOW:   cfg.stop_band_low    = pwdata[9:0];
                    cbcs_pkg::REG_STOP_HIGH:  cfg.stop_band_high   = pwdata[9:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                hue = s_tdata[7:0];
                sat = s_tdata[15:8];
                bri = s_tdata[23:16];
                px  = s_tdata[33:24];
                py  = s_tdata[43:34];
                // drop marked pixels once the count is full, saturate the sums
                if (hue <= cfg.hue_max && sat >= cfg.sat_min && bri >= cfg.val_min
                    && blob_count != cbcs_pkg::COUNT_MAX)
                begin
                    blob_count = blob_count + 1'b1;
                    acc        = {1'b0, blob_sum_x} + {21'd0, px};
                    blob_sum_x = acc[30] ? cbcs_pkg::SUM_MAX : acc[29:0];
                    acc        = {1'b0, blob_sum_y} + {21'd0, py};
                    blob_sum_y = acc[30] ? cbcs_pkg::SUM_MAX : acc[29:0];
                end

                if (s_tlast)
                begin
                    want.found = 1'b0;
                    if (blob_count > cfg.area_min)
                    begin
                        quot = blob_sum_x / {10'd0, blob_count};
                        if (quot > 30'(cbcs_pkg::COORD_MASK))
                            quot = 30'(cbcs_pkg::COORD_MASK);
                        last_cx = {1'b0, quot[cbcs_pkg::COORD_BITS-1:0]};
                        quot = blob_sum_y / {10'd0, blob_count};
                        if (quot > 30'(cbcs_pkg::COORD_MASK))
                            quot = 30'(cbcs_pkg::COORD_MASK);
                        last_cy = {1'b0, quot[cbcs_pkg::COORD_BITS-1:0]};
                        want.found = 1'b1;
                        found_total++;
                    end
                    blob_count = '0;
                    blob_sum_x = '0;
                    blob_sum_y = '0;

                    // signed compare: a commanded x of -1 lies below the stop band
                    cur_x     = int'(last_cx);
                    prev_x    = int'(steered_x);
                    left_lim  = int'(cfg.turn_left_below);
                    right_lim = int'(cfg.turn_right_above);
                    band_lo   = int'(cfg.stop_band_low);
                    band_hi   = int'(cfg.stop_band_high);
                    want.cmd  = cbcs_pkg::CMD_NONE;
                    if (cur_x != prev_x && cur_x > 0)
                    begin
                        if (cur_x < left_lim)
                            want.cmd = cbcs_pkg::CMD_LEFT;
                        else if (cur_x > right_lim)
                            want.cmd = cbcs_pkg::CMD_RIGHT;
                        else if (prev_x < band_lo || prev_x > band_hi)
                            want.cmd = cbcs_pkg::CMD_STOP;
                        steered_x = last_cx;
                    end
                    want.cx = last_cx;
                    want.cy = last_cy;
                    steer_queue.push_back(want);
                end
            end
        end
        mismatches     <= fail_total;
        frames_pending <= steer_queue.size();
        frames_checked <= checked_total;
        blobs_found    <= found_total;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the blob tracker testbench: clock, reset, APB setup, pixel stimulus,
// output back-pressure, watchdog and verdict. Needs cbcs_pkg, the RTL and blob_steer_checker.
module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    localparam cbcs_pkg::cfg_t CFG_AT_RESET = '{hue_max: 8'd9, sat_min: 8'd160,
                                                val_min: 8'd40, area_min: 20'd400,
                                                turn_left_below: 10'd40,
                                                turn_right_above: 10'd120,
                                                stop_band_low: 10'd60,
                                                stop_band_high: 10'd100};

    // idle mixes: none, sender idle, receiver stalling, both lightly
    localparam int TX_IDLE[4]  = '{0, 79, 0, 7};
    localparam int RX_STALL[4] = '{0, 0, 79, 7};

    logic        clk;
    logic        rst_n    = 1'b0;
    // [7:0] hue, [15:8] saturation, [23:16] brightness,
    // [33:24] pos_x, [43:34] pos_y, [47:44] zero
    logic [47:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tlast  = 1'b0;
    // [1:0] command, [2] found, [13:3] centroid_x, [24:14] centroid_y, [31:25] zero
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int             mismatches;
    int             frames_pending;
    int             frames_checked;
    int             blobs_found;
    int             pixels_sent  = 0;
    int             tx_idle_pct  = 0;
    int             rx_stall_pct = 0;
    bit             hold_req     = 1'b0;
    cbcs_pkg::cfg_t shadow       = CFG_AT_RESET;

    color_blob_centroid_steer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    blob_steer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tlast        (s_tlast),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked),
        .blobs_found    (blobs_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat accepted for %0d cycles, %0d frames still pending",
                 IDLE_LIMIT, frames_pending);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic set_idle_mix(input int mix);
        tx_idle_pct  = TX_IDLE[mix];
        rx_stall_pct = RX_STALL[mix];
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] word;
        // junk above the field width must be masked off by the block
        word = ($urandom << width) | value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic write_config(input cbcs_pkg::cfg_t c);
        shadow = c;
        reg_write(cbcs_pkg::REG_HUE_MAX,    32'(c.hue_max),          8);
        reg_write(cbcs_pkg::REG_SAT_MIN,    32'(c.sat_min),          8);
        reg_write(cbcs_pkg::REG_VAL_MIN,    32'(c.val_min),          8);
        reg_write(cbcs_pkg::REG_AREA_MIN,   32'(c.area_min),         20);
        reg_write(cbcs_pkg::REG_TURN_LEFT,  32'(c.turn_left_below),  10);
        reg_write(cbcs_pkg::REG_TURN_RIGHT, 32'(c.turn_right_above), 10);
        reg_write(cbcs_pkg::REG_STOP_LOW,   32'(c.stop_band_low),    10);
        reg_write(cbcs_pkg::REG_STOP_HIGH,  32'(c.stop_band_high),   10);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri, input logic [9:0] px,
                              input logic [9:0] py, input logic eop);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, py, px, bri, sat, hue};
        s_tlast  <= eop;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // one frame clustered around a random center; noise frames are fully random pixels
    task automatic send_frame(input int len, input int mark_pct, input bit noise);
        int         cx;
        int         cy;
        int         spread;
        int         x;
        int         y;
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] v;
        cx     = ($urandom_range(0, 7) == 0) ? 1023 * $urandom_range(0, 1)
                                             : $urandom_range(0, 1023);
        cy     = $urandom_range(0, 1023);
        spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
        begin
            if (noise)
            begin
                h = 8'($urandom_range(0, 179));
                s = 8'($urandom_range(0, 255));
                v = 8'($urandom_range(0, 255));
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end
            else
            begin
                h = 8'($urandom_range(0, shadow.hue_max));
                s = 8'($urandom_range(shadow.sat_min, 255));
                v = 8'($urandom_range(shadow.val_min, 255));
                // break one threshold where the setting leaves room to miss it
                if ($urandom_range(0, 99) >= mark_pct)
                    case ($urandom_range(0, 2))
                        0: if (shadow.hue_max < 179)
                               h = 8'($urandom_range(shadow.hue_max + 1, 179));
                        1: if (shadow.sat_min > 0)
                               s = 8'($urandom_range(0, shadow.sat_min - 1));
                        default: if (shadow.val_min > 0)
                                     v = 8'($urandom_range(0, shadow.val_min - 1));
                    endcase
                x = cx + int'($urandom_range(0, 2 * spread)) - spread;
                y = cy + int'($urandom_range(0, 2 * spread)) - spread;
                x = (x < 0) ? 0 : ((x > 1023) ? 1023 : x);
                y = (y < 0) ? 0 : ((y > 1023) ? 1023 : y);
            end
            send_pixel(h, s, v, 10'(x), 10'(y), i == len - 1);
        end
    endtask

    // let every predicted result come out and the divider go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (frames_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cbcs_pkg::cfg_t pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, count far below the area minimum
        set_idle_mix(0);
        send_pixel(8'd0, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b0);
        send_pixel(8'd179, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1);
        settle();

        // any marked pixel is a blob: walk the steering decisions
        pick = CFG_AT_RESET;
        pick.area_min = '0;
        write_config(pick);
        send_pixel(8'd0, 8'd200, 8'd200, 10'd0, 10'd0, 1'b1);       // centroid at zero
        send_pixel(8'd5, 8'd200, 8'd200, 10'd20, 10'd5, 1'b1);      // left
        send_pixel(8'd5, 8'd200, 8'd200, 10'd20, 10'd700, 1'b1);    // same x, hold
        send_pixel(8'd5, 8'd200, 8'd200, 10'd1023, 10'd1023, 1'b1); // right
        send_pixel(8'd5, 8'd200, 8'd200, 10'd80, 10'd9, 1'b1);      // middle, outside band
        send_pixel(8'd5, 8'd200, 8'd200, 10'd90, 10'd9, 1'b1);      // middle, inside band
        send_pixel(8'd200, 8'd200, 8'd200, 10'd5, 10'd5, 1'b1);     // nothing marked
        // one step past each threshold, then exactly on all three
        send_pixel(8'd10, 8'd255, 8'd255, 10'd500, 10'd500, 1'b0);
        send_pixel(8'd9, 8'd159, 8'd255, 10'd1000, 10'd1000, 1'b0);
        send_pixel(8'd9, 8'd255, 8'd39, 10'd1000, 10'd1000, 1'b0);
        send_pixel(8'd9, 8'd160, 8'd40, 10'd30, 10'd3, 1'b1);
        send_pixel(8'd0, 8'd160, 8'd40, 10'd50, 10'd3, 1'b1);       // stop from below band
        settle();

        // count must exceed the area minimum, not reach it
        pick.area_min = 20'd1;
        write_config(pick);
        send_pixel(8'd1, 8'd170, 8'd50, 10'd600, 10'd600, 1'b1);
        send_pixel(8'd1, 8'd170, 8'd50, 10'd700, 10'd100, 1'b0);
        send_pixel(8'd1, 8'd170, 8'd50, 10'd701, 10'd101, 1'b1);
        settle();

        // reset settings again: one frame just over the default area
        write_config(CFG_AT_RESET);
        send_frame(402, 100, 1'b0);
        for (int f = 0; f < 3; f++)
            send_frame(5, 80, 1'b0);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: pick = '{hue_max: 8'd179, sat_min: 8'd0, val_min: 8'd0, area_min: 20'd0,
                            turn_left_below: 10'd0, turn_right_above: 10'd1023,
                            stop_band_low: 10'd0, stop_band_high: 10'd1023};
                1: pick = '{hue_max: 8'd0, sat_min: 8'd255, val_min: 8'd255,
                            area_min: 20'hFFFFF, turn_left_below: 10'd1023,
                            turn_right_above: 10'd0, stop_band_low: 10'd1023,
                            stop_band_high: 10'd0};
                default:
                begin
                    pick.hue_max  = 8'($urandom_range(0, 179));
                    pick.sat_min  = 8'($urandom_range(0, 220));
                    pick.val_min  = 8'($urandom_range(0, 220));
                    pick.area_min = 20'($urandom_range(0, 6));
                    if (p % 2 == 0)
                    begin
                        // ordered limits reach every steering branch
                        pick.turn_left_below  = 10'($urandom_range(1, 400));
                        pick.turn_right_above = 10'($urandom_range(600, 1022));
                        pick.stop_band_low    = 10'($urandom_range(pick.turn_left_below, 511));
                        pick.stop_band_high   = 10'($urandom_range(512, pick.turn_right_above));
                    end
                    else
                    begin
                        pick.turn_left_below  = 10'($urandom_range(0, 1023));
                        pick.turn_right_above = 10'($urandom_range(0, 1023));
                        pick.stop_band_low    = 10'($urandom_range(0, 1023));
                        pick.stop_band_high   = 10'($urandom_range(0, 1023));
                    end
                end
            endcase
            set_idle_mix(p % 4);
            write_config(pick);
            for (int f = 0; f < 16; f++)
                send_frame($urandom_range(1, 16), $urandom_range(30, 100),
                           $urandom_range(0, 99) < 15);
            settle();
        end

        // short frames against a long output hold-off fill the frame queue
        set_idle_mix(0);
        pick.area_min = 20'($urandom_range(0, 1));
        write_config(pick);
        hold_req = 1'b1;
        for (int f = 0; f < 24; f++)
            send_frame($urandom_range(1, 2), 100, 1'b0);
        settle();

        $display("Sent %0d pixels in %0d frames, %0d of them with a blob over the area limit.",
                 pixels_sent, frames_checked, blobs_found);
        $display("Ran default, extreme and random thresholds under all idle mixes and a hold-off.");
        if (mismatches == 0 && frames_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
